// ----- hdl/bmr_pkg.sv -----
// Package with shared types and constants of the basic matrix reduction core.
package bmr_pkg;

    localparam int DATA_W    = 64;
    localparam int MAX_COLS  = 64;
    localparam int COL_W     = 7;
    localparam int SRC_IDX_W = 6;
    localparam int STATUS_W  = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVER = 2'd2;

    localparam logic [COL_W-1:0] COLS_RESET = 7'd64;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RED_RD,
        ST_RED_CMP,
        ST_EMIT_RD,
        ST_EMIT_WR,
        ST_ERR
    } t_bmr_state;

    typedef struct packed {
        logic in_ready;
        logic clear;
        logic scan_reset;
        logic scan_next;
        logic mem_rd;
        logic mark_en;
        logic out_load_row;
        logic out_load_err;
    } t_bmr_cmd;

    typedef struct packed {
        logic last_fire;
        logic err_next;
        logic scan_done;
        logic scan_removed;
        logic out_free;
    } t_bmr_sts;

endpackage

// ----- hdl/bmr_if.sv -----
// Channel interfaces for row input, result output and the configuration write.
interface bmr_in_if;
    logic                      valid;
    logic                      ready;
    logic [bmr_pkg::DATA_W-1:0] row_bits;
    logic                      last_row;

    modport source (output valid, output row_bits, output last_row, input ready);
    modport sink (input valid, input row_bits, input last_row, output ready);
endinterface

interface bmr_out_if;
    logic                         valid;
    logic                         ready;
    logic [bmr_pkg::DATA_W-1:0]    kept_bits;
    logic [bmr_pkg::SRC_IDX_W-1:0] source_index;
    logic [bmr_pkg::STATUS_W-1:0]  status;
    logic                         last_result;

    modport source (output valid, output kept_bits, output source_index, output status,
                    output last_result, input ready);
    modport sink (input valid, input kept_bits, input source_index, input status,
                  input last_result, output ready);
endinterface

interface bmr_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [bmr_pkg::COL_W-1:0] column_count;

    modport source (output valid, output column_count, input ready);
    modport sink (input valid, input column_count, output ready);
endinterface

// ----- hdl/basic_matrix_reduction_core.sv -----
// Top level of the basic matrix reduction core.
// Rows are taken one per cycle until a beat with last_row set. After that the input stalls
// while the matrix is reduced: each loaded row is read from the row memory and then
// compared at once against all rows held in the compare cells. Emission then skips each
// removed row and reads each kept row through the single read port of the row memory
// before loading it into the result register, which waits on any output stall. A matrix
// with an all-zero row or too many rows gives one error beat.
module basic_matrix_reduction_core #(
    parameter int MAX_ROWS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bmr_in_if.sink     i_row_ch,
    bmr_cfg_if.sink    i_cfg_ch,
    bmr_out_if.source  o_res_ch
);

    bmr_pkg::t_bmr_cmd cmd;
    bmr_pkg::t_bmr_sts sts;

    assign i_row_ch.ready = cmd.in_ready;
    assign i_cfg_ch.ready = 1'b1;

    bmr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bmr_dp #(
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_row_valid    (i_row_ch.valid),
        .i_row_bits     (i_row_ch.row_bits),
        .i_last_row     (i_row_ch.last_row),
        .i_cfg_valid    (i_cfg_ch.valid),
        .i_column_count (i_cfg_ch.column_count),
        .i_out_ready    (o_res_ch.ready),
        .o_out_valid    (o_res_ch.valid),
        .o_kept_bits    (o_res_ch.kept_bits),
        .o_source_index (o_res_ch.source_index),
        .o_status       (o_res_ch.status),
        .o_last_result  (o_res_ch.last_result)
    );

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_ch.valid && (o_res_ch.status != bmr_pkg::STATUS_OK)) |-> o_res_ch.last_result)
        else $error("Error result beat without last_result.");

    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.out_load_row && cmd.out_load_err))
        else $error("Row and error result loaded in the same cycle.");

    a_no_load_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.out_load_row || cmd.out_load_err) |-> !cmd.in_ready)
        else $error("Result produced while rows are being accepted.");

    a_kept_not_removed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load_row |-> !sts.scan_removed)
        else $error("Removed row emitted as a result.");

endmodule

// ----- hdl/bmr_ctrl.sv -----
// Controller state machine that sequences loading, reduction and result emission.
module bmr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bmr_pkg::t_bmr_sts i_sts,
    output bmr_pkg::t_bmr_cmd o_cmd
);

    bmr_pkg::t_bmr_state r_state;
    bmr_pkg::t_bmr_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bmr_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bmr_pkg::ST_LOAD: begin
                if (i_sts.last_fire) begin
                    n_state = i_sts.err_next ? bmr_pkg::ST_ERR : bmr_pkg::ST_RED_RD;
                end
            end
            bmr_pkg::ST_RED_RD: begin
                n_state = i_sts.scan_done ? bmr_pkg::ST_EMIT_RD : bmr_pkg::ST_RED_CMP;
            end
            bmr_pkg::ST_RED_CMP: begin
                n_state = bmr_pkg::ST_RED_RD;
            end
            bmr_pkg::ST_EMIT_RD: begin
                priority if (i_sts.scan_done) begin
                    n_state = bmr_pkg::ST_LOAD;
                end else if (!i_sts.scan_removed) begin
                    n_state = bmr_pkg::ST_EMIT_WR;
                end
            end
            bmr_pkg::ST_EMIT_WR: begin
                if (i_sts.out_free) begin
                    n_state = bmr_pkg::ST_EMIT_RD;
                end
            end
            bmr_pkg::ST_ERR: begin
                if (i_sts.out_free) begin
                    n_state = bmr_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = bmr_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            bmr_pkg::ST_LOAD: begin
                o_cmd.in_ready   = 1'b1;
                o_cmd.scan_reset = 1'b1;
            end
            bmr_pkg::ST_RED_RD: begin
                if (i_sts.scan_done) begin
                    o_cmd.scan_reset = 1'b1;
                end else begin
                    o_cmd.mem_rd = 1'b1;
                end
            end
            bmr_pkg::ST_RED_CMP: begin
                o_cmd.mark_en   = 1'b1;
                o_cmd.scan_next = 1'b1;
            end
            bmr_pkg::ST_EMIT_RD: begin
                priority if (i_sts.scan_done) begin
                    o_cmd.clear = 1'b1;
                end else if (i_sts.scan_removed) begin
                    o_cmd.scan_next = 1'b1;
                end else begin
                    o_cmd.mem_rd = 1'b1;
                end
            end
            bmr_pkg::ST_EMIT_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load_row = 1'b1;
                    o_cmd.scan_next    = 1'b1;
                end
            end
            bmr_pkg::ST_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load_err = 1'b1;
                    o_cmd.clear        = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ----- hdl/bmr_dp.sv -----
// Datapath with the row memory, the row compare cells, removal marks and the result register.
module bmr_dp #(
    parameter int MAX_ROWS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bmr_pkg::t_bmr_cmd               i_cmd,
    output bmr_pkg::t_bmr_sts               o_sts,
    input  logic                            i_row_valid,
    input  logic [bmr_pkg::DATA_W-1:0]      i_row_bits,
    input  logic                            i_last_row,
    input  logic                            i_cfg_valid,
    input  logic [bmr_pkg::COL_W-1:0]       i_column_count,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [bmr_pkg::DATA_W-1:0]      o_kept_bits,
    output logic [bmr_pkg::SRC_IDX_W-1:0]   o_source_index,
    output logic [bmr_pkg::STATUS_W-1:0]    o_status,
    output logic                            o_last_result
);

    localparam int CNT_W = $clog2(MAX_ROWS + 1);
    localparam int IDX_W = $clog2(MAX_ROWS);

    logic [bmr_pkg::COL_W-1:0]  r_column_count;
    logic [CNT_W-1:0]           r_rows_loaded;
    logic                       r_zero_seen;
    logic                       r_over_seen;
    logic [CNT_W-1:0]           r_scan;
    logic [MAX_ROWS-1:0]        r_removed;
    logic [bmr_pkg::DATA_W-1:0] r_mem [MAX_ROWS];
    logic [bmr_pkg::DATA_W-1:0] r_cells [MAX_ROWS];
    logic [bmr_pkg::DATA_W-1:0] r_mem_q;

    logic                       r_out_valid;
    logic [bmr_pkg::DATA_W-1:0] r_kept_bits;
    logic [IDX_W-1:0]           r_source_index;
    logic [bmr_pkg::STATUS_W-1:0] r_status;
    logic                       r_last_result;

    logic [bmr_pkg::COL_W-1:0]  cols_eff;
    logic [bmr_pkg::DATA_W-1:0] col_mask;
    logic [bmr_pkg::DATA_W-1:0] row_masked;
    logic                       row_fire;
    logic                       store_full;
    logic                       store_en;
    logic [IDX_W-1:0]           load_idx;
    logic [IDX_W-1:0]           scan_idx;
    logic [MAX_ROWS-1:0]        row_valid;
    logic [MAX_ROWS-1:0]        subset_hit;
    logic [MAX_ROWS-1:0]        kept_above;
    logic                       mark_now;
    logic                       out_free;

    assign cols_eff = (r_column_count > bmr_pkg::COL_W'(bmr_pkg::MAX_COLS)) ?
                      bmr_pkg::COL_W'(bmr_pkg::MAX_COLS) : r_column_count;
    assign col_mask = (cols_eff >= bmr_pkg::COL_W'(bmr_pkg::DATA_W)) ? '1 :
                      ((bmr_pkg::DATA_W'(1) << cols_eff) - bmr_pkg::DATA_W'(1));
    assign row_masked = i_row_bits & col_mask;
    assign row_fire   = i_row_valid & i_cmd.in_ready;
    assign store_full = (r_rows_loaded == CNT_W'(MAX_ROWS));
    assign store_en   = row_fire & !store_full;
    assign load_idx   = r_rows_loaded[IDX_W-1:0];
    assign scan_idx   = r_scan[IDX_W-1:0];
    assign out_free   = !r_out_valid | i_out_ready;

    always_comb begin
        for (int j = 0; j < MAX_ROWS; j++) begin
            row_valid[j]  = (CNT_W'(j) < r_rows_loaded);
            subset_hit[j] = ((r_cells[j] & ~r_mem_q) == '0) && row_valid[j] &&
                            !r_removed[j] && (CNT_W'(j) != r_scan);
            kept_above[j] = row_valid[j] && !r_removed[j] && (CNT_W'(j) > r_scan);
        end
    end

    assign mark_now = |subset_hit;

    assign o_sts.last_fire    = row_fire & i_last_row;
    assign o_sts.err_next     = r_over_seen | r_zero_seen | store_full |
                                (row_masked == '0);
    assign o_sts.scan_done    = (r_scan == r_rows_loaded);
    assign o_sts.scan_removed = r_removed[scan_idx];
    assign o_sts.out_free     = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_count <= bmr_pkg::COLS_RESET;
        end else if (i_cfg_valid) begin
            r_column_count <= i_column_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_loaded <= '0;
            r_zero_seen   <= 1'b0;
            r_over_seen   <= 1'b0;
            r_removed     <= '0;
        end else if (i_cmd.clear) begin
            r_rows_loaded <= '0;
            r_zero_seen   <= 1'b0;
            r_over_seen   <= 1'b0;
            r_removed     <= '0;
        end else begin
            if (store_en) begin
                r_rows_loaded <= r_rows_loaded + CNT_W'(1);
                if (row_masked == '0) begin
                    r_zero_seen <= 1'b1;
                end
            end else if (row_fire) begin
                r_over_seen <= 1'b1;
            end
            if (i_cmd.mark_en && mark_now) begin
                r_removed[scan_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else if (i_cmd.scan_reset) begin
            r_scan <= '0;
        end else if (i_cmd.scan_next) begin
            r_scan <= r_scan + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_en) begin
            r_mem[load_idx] <= row_masked;
        end
        if (i_cmd.mem_rd) begin
            r_mem_q <= r_mem[scan_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_ROWS; j++) begin
            if (store_en && (load_idx == IDX_W'(j))) begin
                r_cells[j] <= row_masked;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load_row || i_cmd.out_load_err) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load_row) begin
            r_kept_bits    <= r_mem_q;
            r_source_index <= scan_idx;
            r_status       <= bmr_pkg::STATUS_OK;
            r_last_result  <= !(|kept_above);
        end else if (i_cmd.out_load_err) begin
            r_kept_bits    <= '0;
            r_source_index <= '0;
            r_status       <= r_over_seen ? bmr_pkg::STATUS_OVER : bmr_pkg::STATUS_ZERO;
            r_last_result  <= 1'b1;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kept_bits    = r_kept_bits;
    assign o_source_index = bmr_pkg::SRC_IDX_W'(r_source_index);
    assign o_status       = r_status;
    assign o_last_result  = r_last_result;

endmodule

// ----- tb/bmr_result_checker.sv -----
// Result checker for the basic matrix reduction core: predicts every result beat and compares.
module bmr_result_checker #(
    parameter int MAX_ROWS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bmr_in_if    row_ch,
    bmr_cfg_if   cfg_ch,
    bmr_out_if   res_ch,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [bmr_pkg::DATA_W-1:0]    kept_bits;
        logic [bmr_pkg::SRC_IDX_W-1:0] source_index;
        logic [bmr_pkg::STATUS_W-1:0]  status;
        logic                          last_result;
    } t_reduced_row;

    t_reduced_row               expected_rows_q[$];
    logic [bmr_pkg::DATA_W-1:0] held_rows [MAX_ROWS];
    int                         rows_held;
    bit                         zero_seen;
    bit                         over_seen;
    logic [bmr_pkg::COL_W-1:0]  col_count;

    function automatic logic [bmr_pkg::DATA_W-1:0] column_mask(
        input logic [bmr_pkg::COL_W-1:0] cols);
        int width;
        width = (cols > bmr_pkg::MAX_COLS) ? bmr_pkg::MAX_COLS : int'(cols);
        if (width >= bmr_pkg::DATA_W) begin
            return {bmr_pkg::DATA_W{1'b1}};
        end
        return (64'h1 << width) - 64'h1;
    endfunction

    task automatic report(input string msg);
        $display("Mismatch at %0t ns: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic load_row(input logic [bmr_pkg::DATA_W-1:0] bits, input logic last);
        logic [bmr_pkg::DATA_W-1:0] row;
        bit                         removed [MAX_ROWS];
        bit                         covered;
        int                         last_pos;
        t_reduced_row               res;
        row = bits & column_mask(col_count);
        if (rows_held < MAX_ROWS) begin
            held_rows[rows_held] = row;
            if (row == '0) begin
                zero_seen = 1'b1;
            end
            rows_held++;
        end else begin
            over_seen = 1'b1;
        end
        if (!last) begin
            return;
        end
        if (over_seen || zero_seen) begin
            res.kept_bits    = '0;
            res.source_index = '0;
            res.status       = over_seen ? bmr_pkg::STATUS_OVER : bmr_pkg::STATUS_ZERO;
            res.last_result  = 1'b1;
            expected_rows_q.push_back(res);
        end else begin
            // Rows are visited in load order; a row goes when a live row is a subset of it.
            for (int i = 0; i < rows_held; i++) begin
                covered = 1'b0;
                for (int j = 0; j < rows_held; j++) begin
                    if (j != i && !removed[j] && (held_rows[j] & ~held_rows[i]) == '0) begin
                        covered = 1'b1;
                    end
                end
                removed[i] = covered;
            end
            last_pos = -1;
            for (int i = 0; i < rows_held; i++) begin
                if (!removed[i]) begin
                    last_pos = i;
                end
            end
            for (int i = 0; i < rows_held; i++) begin
                if (!removed[i]) begin
                    res.kept_bits    = held_rows[i];
                    res.source_index = bmr_pkg::SRC_IDX_W'(i);
                    res.status       = bmr_pkg::STATUS_OK;
                    res.last_result  = (i == last_pos);
                    expected_rows_q.push_back(res);
                end
            end
        end
        rows_held = 0;
        zero_seen = 1'b0;
        over_seen = 1'b0;
    endtask

    task automatic compare_result();
        t_reduced_row exp_row;
        if (expected_rows_q.size() == 0) begin
            report($sformatf("result beat %h/%0d with nothing expected",
                             res_ch.kept_bits, res_ch.source_index));
            return;
        end
        exp_row = expected_rows_q.pop_front();
        if (res_ch.kept_bits !== exp_row.kept_bits) begin
            report($sformatf("kept_bits got %h expected %h",
                             res_ch.kept_bits, exp_row.kept_bits));
        end
        if (res_ch.source_index !== exp_row.source_index) begin
            report($sformatf("source_index got %0d expected %0d",
                             res_ch.source_index, exp_row.source_index));
        end
        if (res_ch.status !== exp_row.status) begin
            report($sformatf("status got %0d expected %0d", res_ch.status, exp_row.status));
        end
        if (res_ch.last_result !== exp_row.last_result) begin
            report($sformatf("last_result got %b expected %b",
                             res_ch.last_result, exp_row.last_result));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_rows_q.delete();
            rows_held    = 0;
            zero_seen    = 1'b0;
            over_seen    = 1'b0;
            col_count    = bmr_pkg::COLS_RESET;
            o_fail_count = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                compare_result();
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                col_count = cfg_ch.column_count;
            end
            if (row_ch.valid && row_ch.ready) begin
                load_row(row_ch.row_bits, row_ch.last_row);
            end
        end
        o_pending = expected_rows_q.size();
    end

endmodule

// ----- tb/tb_basic_matrix_reduction_core.sv -----
// Testbench top for the basic matrix reduction core: clock, reset, row and column stimulus.
module tb_basic_matrix_reduction_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                         MAX_ROWS     = 64;
    localparam int                         RANDOM_ITEMS = 250;
    localparam int                         CYCLE_LIMIT  = 300000;
    localparam logic [bmr_pkg::DATA_W-1:0] ALL_ONES     = {bmr_pkg::DATA_W{1'b1}};

    logic                       i_clk;
    logic                       i_rst_n;
    int                         fail_count;
    int                         pending;
    int                         cycle_count;
    int                         items_sent;
    int                         directed_items;
    int                         kind;
    bit                         send_idle;
    bit                         recv_idle;
    logic [bmr_pkg::COL_W-1:0]  cur_cols;
    logic [bmr_pkg::DATA_W-1:0] matrix_q[$];

    bmr_in_if  row_ch ();
    bmr_cfg_if cfg_ch ();
    bmr_out_if res_ch ();

    basic_matrix_reduction_core #(
        .MAX_ROWS (MAX_ROWS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_row_ch (row_ch),
        .i_cfg_ch (cfg_ch),
        .o_res_ch (res_ch)
    );

    bmr_result_checker #(
        .MAX_ROWS (MAX_ROWS)
    ) u_result_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .row_ch       (row_ch),
        .cfg_ch       (cfg_ch),
        .res_ch       (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [bmr_pkg::DATA_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic int used_width();
        return (cur_cols > bmr_pkg::MAX_COLS) ? bmr_pkg::MAX_COLS : int'(cur_cols);
    endfunction

    function automatic logic [bmr_pkg::DATA_W-1:0] used_columns();
        if (used_width() >= bmr_pkg::DATA_W) begin
            return ALL_ONES;
        end
        return (64'h1 << used_width()) - 64'h1;
    endfunction

    function automatic logic [bmr_pkg::DATA_W-1:0] one_hot();
        if (used_width() == 0) begin
            return '0;
        end
        return 64'h1 << $urandom_range(0, used_width() - 1);
    endfunction

    // Half of the rows are built from earlier rows of the same matrix so that subsets and
    // duplicates are common; in half of the rows the bits above the columns in use carry random noise.
    function automatic logic [bmr_pkg::DATA_W-1:0] make_row();
        logic [bmr_pkg::DATA_W-1:0] base;
        logic [bmr_pkg::DATA_W-1:0] row;
        base = (matrix_q.size() > 0) ? matrix_q[$urandom_range(0, matrix_q.size() - 1)]
                                     : rand_word();
        case ($urandom_range(0, 9))
            0, 1, 2: row = one_hot() | one_hot();
            3, 4:    row = rand_word();
            5, 6, 7: row = base | one_hot();
            8:       row = base;
            default: row = base & rand_word();
        endcase
        if ((row & used_columns()) == '0) begin
            row |= one_hot();
        end
        if ($urandom_range(0, 1) == 1) begin
            row |= rand_word() & ~used_columns();
        end
        return row;
    endfunction

    task automatic build_matrix(input int rows, input bit with_zero);
        matrix_q.delete();
        repeat (rows) begin
            matrix_q.push_back(make_row());
        end
        if (with_zero) begin
            matrix_q[$urandom_range(0, rows - 1)] = rand_word() & ~used_columns();
        end
    endtask

    task automatic send_row(input logic [bmr_pkg::DATA_W-1:0] bits, input logic last);
        int gap;
        gap = send_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            row_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        row_ch.valid    <= 1'b1;
        row_ch.row_bits <= bits;
        row_ch.last_row <= last;
        do @(posedge i_clk); while (!row_ch.ready);
        @(negedge i_clk);
        items_sent++;
        if (last) begin
            row_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic send_matrix();
        foreach (matrix_q[i]) begin
            send_row(matrix_q[i], i == matrix_q.size() - 1);
        end
        matrix_q.delete();
    endtask

    task automatic write_cols(input logic [bmr_pkg::COL_W-1:0] cols);
        while (pending != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.column_count <= cols;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        cur_cols = cols;
    endtask

    initial begin : result_sink
        int gap;
        int stretch;
        res_ch.ready = 1'b0;
        stretch      = 0;
        forever begin
            if (stretch == 0) begin
                recv_idle = ($urandom_range(0, 2) != 0);
                stretch   = $urandom_range(5, 30);
            end
            stretch--;
            gap = recv_idle ? $urandom_range(0, 4) : 0;
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
            @(negedge i_clk);
        end
    end

    initial begin
        row_ch.valid        = 1'b0;
        row_ch.row_bits     = '0;
        row_ch.last_row     = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.column_count = bmr_pkg::COLS_RESET;
        i_rst_n             = 1'b0;
        cur_cols            = bmr_pkg::COLS_RESET;
        cycle_count         = 0;
        items_sent          = 0;
        send_idle           = 1'b1;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        matrix_q = '{ALL_ONES};
        send_matrix();
        matrix_q = '{64'h1, 64'h3, 64'h8000_0000_0000_0000, 64'h1};
        send_matrix();
        matrix_q = '{64'h5, 64'h0, 64'hF};
        send_matrix();
        matrix_q = '{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, ALL_ONES};
        send_matrix();
        write_cols(7'd1);
        matrix_q = '{64'hFFFF_FFFF_FFFF_FFFE};
        send_matrix();
        matrix_q = '{ALL_ONES};
        send_matrix();
        write_cols(7'd0);
        matrix_q = '{ALL_ONES};
        send_matrix();
        write_cols(7'd127);
        matrix_q = '{64'h8000_0000_0000_0001};
        send_matrix();
        directed_items = items_sent;

        write_cols(7'd64);
        build_matrix(MAX_ROWS + 1, 1'b1);
        send_matrix();
        while (pending != 0) @(negedge i_clk);
        for (int i = 0; i < MAX_ROWS; i++) begin
            matrix_q.push_back(($urandom_range(0, 3) == 0) ? rand_word() : (64'h1 << i));
        end
        send_matrix();

        while (items_sent - directed_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 9))
                    0:       write_cols(7'd0);
                    1:       write_cols(7'd127);
                    2:       write_cols(7'd1);
                    3, 4:    write_cols(7'd64);
                    default: write_cols(bmr_pkg::COL_W'($urandom_range(2, 63)));
                endcase
            end
            if ($urandom_range(0, 9) == 0) begin
                while (pending != 0) @(negedge i_clk);
            end
            send_idle = ($urandom_range(0, 3) != 0);
            kind      = $urandom_range(0, 99);
            if (kind < 2) begin
                build_matrix($urandom_range(MAX_ROWS + 1, MAX_ROWS + 3), $urandom_range(0, 1));
            end else if (kind < 5) begin
                build_matrix($urandom_range(20, MAX_ROWS), 1'b0);
            end else if (kind < 15) begin
                build_matrix($urandom_range(1, 8), 1'b1);
            end else begin
                build_matrix($urandom_range(1, 10), 1'b0);
            end
            send_matrix();
        end

        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
